@@ hdl/spu_pkg.sv @@
// Shared types, constants and saturation helper for the swirl particle update block.
// Used by spu_front, spu_fifo, spu_back and swirl_particle_update.
package spu_pkg;

  localparam int WORD_W      = 32;
  localparam int LIFE_W      = 17;
  localparam int BOUNCE_W    = 17;
  localparam int WEIGHT_W    = 31;
  localparam int IN_TDATA_W  = 360;
  localparam int OUT_TDATA_W = 312;
  localparam int CFG_IDX_W   = 1;
  localparam int QDEPTH      = 4;
  localparam int QAW         = 2;

  localparam logic MODE_TORNADO = 1'b0;
  localparam logic MODE_SMOKE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMITTER = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t                      px;
    word_t                      py;
    word_t                      pz;
    word_t                      vx;
    word_t                      vy;
    word_t                      vz;
    word_t                      ox;
    word_t                      oy;
    word_t                      oz;
    word_t                      fx;
    word_t                      fy;
    word_t                      fz;
    logic signed [LIFE_W-1:0]   life;
    logic                       hit;
    logic                       bounce_en;
    logic [BOUNCE_W-1:0]        bounce;
    logic [WEIGHT_W-1:0]        weight;
  } item_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/swirl_particle_update.sv @@
// Swirl particle update: takes one particle per clock and returns its state one frame on.
// The block accepts a transaction every cycle and delivers one per cycle while m_tready is
// high; its pipeline depth is set by the one-bit-per-stage square root and dividers. Dead
// particles produce no output transaction. Depends on spu_pkg, spu_front, spu_fifo and
// spu_back.
module swirl_particle_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, bounce_factor, mass_weight,
  // force_x, force_y, force_z, zero fill
  input  logic [spu_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, prev_x, prev_y,
  // prev_z, new_life, hit_floor, zero fill
  output logic [spu_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [spu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spu_pkg::WORD_W-1:0]      cfg_data
);
  import spu_pkg::*;

  item_t push_item, pop_item;
  logic  push, full, pop, qvalid;

  spu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  spu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .valid     (qvalid),
    .pop_item  (pop_item)
  );

  spu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qvalid),
    .q_item   (pop_item),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ hdl/spu_front.sv @@
// Front end: holds the configuration registers, takes input transactions, drops dead
// particles, applies the move, the floor test and the life update. Depends on spu_pkg.
module spu_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spu_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            cfg_we,
  input  logic [spu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spu_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output spu_pkg::item_t                  q_item
);
  import spu_pkg::*;

  logic  mode;
  word_t emitter_height;

  word_t px, py, pz, vx, vy, vz, fx, fy, fz;
  word_t px1, py1, pz1;
  logic signed [LIFE_W-1:0] life;
  logic [BOUNCE_W-1:0] bounce;
  logic [WEIGHT_W-1:0] weight;
  logic live, hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_TORNADO;
      emitter_height <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data[0];
      end else if (cfg_index == CFG_EMITTER) begin
        emitter_height <= cfg_data;
      end
    end
  end

  always_comb begin
    px     = s_tdata[31:0];
    py     = s_tdata[63:32];
    pz     = s_tdata[95:64];
    vx     = s_tdata[127:96];
    vy     = s_tdata[159:128];
    vz     = s_tdata[191:160];
    life   = s_tdata[208:192];
    bounce = s_tdata[225:209];
    weight = s_tdata[256:226];
    fx     = s_tdata[288:257];
    fy     = s_tdata[320:289];
    fz     = s_tdata[352:321];

    live = life > 17'sd0;
    px1  = sat32(64'(px) + 64'(vx));
    py1  = sat32(64'(py) + 64'(vy));
    pz1  = sat32(64'(pz) + 64'(vz));
    hit  = 64'(pz1) <= -64'(emitter_height);

    q_item           = '0;
    q_item.px        = px1;
    q_item.py        = py1;
    q_item.vx        = vx;
    q_item.vy        = vy;
    q_item.vz        = vz;
    q_item.ox        = px;
    q_item.oy        = py;
    q_item.oz        = pz;
    q_item.fx        = fx;
    q_item.fy        = fy;
    q_item.fz        = fz;
    q_item.hit       = hit;
    q_item.bounce_en = hit && (mode == MODE_TORNADO);
    q_item.pz        = q_item.bounce_en ? '0 : pz1;
    q_item.life      = (hit && (mode == MODE_SMOKE)) ? -17'sd1 : life - 17'sd1;
    q_item.bounce    = bounce;
    q_item.weight    = weight;

    s_tready = !q_full;
    q_push   = s_tvalid && !q_full && live;
  end

endmodule

@@ hdl/spu_fifo.sv @@
// Short queue between the front end and the arithmetic back end.
// Depends on spu_pkg for the item type and depth.
module spu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spu_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output spu_pkg::item_t pop_item
);
  import spu_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  logic do_push, do_pop;

  assign full     = count == (QAW+1)'(QDEPTH);
  assign valid    = count != '0;
  assign pop_item = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/spu_back.sv @@
// Back end pipeline: square root giving the radius, swirl and force dividers, bounce and
// force products, saturation and the output register. Depends on spu_pkg.
module spu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  spu_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spu_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import spu_pkg::*;

  localparam int NUMW   = 32 + FRAC_BITS;
  localparam int SQW    = FRAC_BITS + 1;
  localparam int NSTEPS = 34 + FRAC_BITS;

  typedef struct packed {
    item_t               it;
    logic [63:0]         sqx;
    logic [63:0]         sqy;
    logic signed [63:0]  pb;
    logic signed [63:0]  pf;
    logic [63:0]         rem_s;
    logic [63:0]         root;
    logic                swirl;
    word_t               vzb;
    logic signed [63:0]  tz;
    word_t               vzf;
    logic [NUMW-1:0]     rx;
    logic [NUMW-1:0]     ry;
    logic [NUMW-1:0]     rfx;
    logic [NUMW-1:0]     rfy;
    logic [SQW-1:0]      qx;
    logic [SQW-1:0]      qy;
    logic [NUMW-1:0]     qfx;
    logic [NUMW-1:0]     qfy;
  } stage_t;

  stage_t st  [0:NSTEPS];
  stage_t nxt [0:NSTEPS-1];
  logic   vld [0:NSTEPS];
  stage_t entry;
  logic   en;

  logic [31:0] mag_px, mag_py, mag_fx, mag_fy;
  logic signed [49:0] pbw;

  stage_t fin;
  logic signed [63:0] sxs, sys, txs, tys;
  logic [63:0] qx64, qy64, qfx64, qfy64;
  word_t npx, npy, nvx, nvy;

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && q_valid;

  always_comb begin
    mag_px = q_item.px[31] ? 32'(-q_item.px) : 32'(q_item.px);
    mag_py = q_item.py[31] ? 32'(-q_item.py) : 32'(q_item.py);
    mag_fx = q_item.fx[31] ? 32'(-q_item.fx) : 32'(q_item.fx);
    mag_fy = q_item.fy[31] ? 32'(-q_item.fy) : 32'(q_item.fy);
    pbw    = q_item.vz * $signed({1'b0, q_item.bounce});

    entry     = '0;
    entry.it  = q_item;
    entry.sqx = 64'(64'(q_item.px) * 64'(q_item.px));
    entry.sqy = 64'(64'(q_item.py) * 64'(q_item.py));
    entry.pb  = 64'(pbw);
    entry.pf  = 64'(q_item.fz) * 64'($signed({1'b0, q_item.weight}));
    entry.rx  = NUMW'(mag_py) << FRAC_BITS;
    entry.ry  = NUMW'(mag_px) << FRAC_BITS;
    entry.rfx = NUMW'(mag_fx) << FRAC_BITS;
    entry.rfy = NUMW'(mag_fy) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= entry;
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    localparam int SB = (k >= 1 && k <= 32) ? 62 - 2 * (k - 1) : 0;
    localparam int SJ = (k >= 33) ? 33 + FRAC_BITS - k : 0;
    localparam int FJ = (k >= 1 && k <= 32 + FRAC_BITS) ? 32 + FRAC_BITS - k : 0;

    logic [63:0]     bit_v, trial;
    logic [NUMW-1:0] rdiv, wdiv;

    always_comb begin
      nxt[k] = st[k];
      bit_v  = 64'(1) << SB;
      trial  = st[k].root + bit_v;
      rdiv   = NUMW'(st[k].root[31:0]);
      wdiv   = NUMW'(st[k].it.weight);
      if (k == 0) begin
        nxt[k].rem_s = st[k].sqx + st[k].sqy;
        nxt[k].root  = '0;
        nxt[k].swirl = (st[k].sqx + st[k].sqy) != 64'd0;
        nxt[k].vzb   = st[k].it.bounce_en ? sat32((-st[k].pb) >>> FRAC_BITS) : st[k].it.vz;
        nxt[k].tz    = st[k].pf >>> FRAC_BITS;
      end
      if (k == 1) begin
        nxt[k].vzf = sat32(64'(st[k].vzb) + st[k].tz);
      end
      if (k >= 1 && k <= 32) begin
        if (st[k].rem_s >= trial) begin
          nxt[k].rem_s = st[k].rem_s - trial;
          nxt[k].root  = (st[k].root >> 1) + bit_v;
        end else begin
          nxt[k].root = st[k].root >> 1;
        end
      end
      if (k >= 33) begin
        if ((st[k].rx >> SJ) >= rdiv) begin
          nxt[k].rx     = st[k].rx - (rdiv << SJ);
          nxt[k].qx[SJ] = 1'b1;
        end
        if ((st[k].ry >> SJ) >= rdiv) begin
          nxt[k].ry     = st[k].ry - (rdiv << SJ);
          nxt[k].qy[SJ] = 1'b1;
        end
      end
      if (k >= 1 && k <= 32 + FRAC_BITS) begin
        if ((st[k].rfx >> FJ) >= wdiv) begin
          nxt[k].rfx     = st[k].rfx - (wdiv << FJ);
          nxt[k].qfx[FJ] = 1'b1;
        end
        if ((st[k].rfy >> FJ) >= wdiv) begin
          nxt[k].rfy     = st[k].rfy - (wdiv << FJ);
          nxt[k].qfy[FJ] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt[k];
      end
    end
  end

  always_comb begin
    fin   = st[NSTEPS];
    qx64  = 64'(fin.qx);
    qy64  = 64'(fin.qy);
    qfx64 = 64'(fin.qfx);
    qfy64 = 64'(fin.qfy);

    if (!fin.swirl) begin
      sxs = '0;
    end else if (fin.it.py > 32'sd0) begin
      sxs = -$signed(qx64);
    end else begin
      sxs = $signed(qx64);
    end
    if (!fin.swirl) begin
      sys = '0;
    end else if (fin.it.px < 32'sd0) begin
      sys = -$signed(qy64);
    end else begin
      sys = $signed(qy64);
    end

    if (fin.it.fx == 32'sd0) begin
      txs = '0;
    end else if (fin.it.fx < 32'sd0) begin
      txs = -$signed(qfx64);
    end else begin
      txs = $signed(qfx64);
    end
    if (fin.it.fy == 32'sd0) begin
      tys = '0;
    end else if (fin.it.fy < 32'sd0) begin
      tys = -$signed(qfy64);
    end else begin
      tys = $signed(qfy64);
    end

    npx = sat32(64'(fin.it.px) + sxs);
    npy = sat32(64'(fin.it.py) + sys);
    nvx = sat32(64'(fin.it.vx) + txs);
    nvy = sat32(64'(fin.it.vy) + tys);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0, fin.it.hit, fin.it.life, fin.it.oz, fin.it.oy, fin.it.ox,
                  fin.vzf, nvy, nvx, fin.it.pz, npy, npx};
    end
  end

endmodule
